>>> src/u8v_pkg.sv
package u8v_pkg;

	// Width of the code point accumulator.
	localparam int unsigned CP_W = 21;

	// Code point limits for the end-of-sequence checks.
	localparam logic [CP_W-1:0] CP_MIN_3BYTE  = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4BYTE  = 21'h010000;
	localparam logic [CP_W-1:0] CP_C1_LO      = 21'h000080;
	localparam logic [CP_W-1:0] CP_C1_HI      = 21'h00009F;
	localparam logic [CP_W-1:0] CP_SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;

	// Byte boundaries used by the front classifier.
	localparam logic [7:0] BYTE_SPACE     = 8'h20;
	localparam logic [7:0] BYTE_DEL       = 8'h7F;
	localparam logic [7:0] BYTE_ASCII_END = 8'h80;
	localparam logic [7:0] BYTE_LEAD2_LO  = 8'hC2;
	localparam logic [7:0] BYTE_LEAD2_HI  = 8'hDF;
	localparam logic [7:0] BYTE_LEAD3_LO  = 8'hE0;
	localparam logic [7:0] BYTE_LEAD3_HI  = 8'hEF;
	localparam logic [7:0] BYTE_LEAD4_LO  = 8'hF0;
	localparam logic [7:0] BYTE_LEAD4_HI  = 8'hF4;

	// Continuation counts of the three multi-byte forms.
	localparam logic [1:0] CONTS_2BYTE = 2'd1;
	localparam logic [1:0] CONTS_3BYTE = 2'd2;
	localparam logic [1:0] CONTS_4BYTE = 2'd3;

	// Class of a byte when it is read as the start of a character.
	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_CTRL,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} lead_cls_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic       has_byte;
		logic       last;
		lead_cls_t  cls;
		logic [7:0] data;
	} item_t;

	// Queue status seen by the top level.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> src/utf8_validator_no_controls_core.sv
// The last item passes the front register and the queue; the back registers its verdict.
// Throughput: one byte per cycle unless stalled; the decoder steps its running state per item.
// A full queue stalls the input; a stalled verdict blocks only the next item marked last.
// Reset (arst_n low, asynchronous) clears the decoder state, the queue pointers and all valids.
// Queue contents and payload registers are not reset.
module utf8_validator_no_controls_core
	import u8v_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_value,
	input  logic       has_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       string_valid
);

	logic      f_valid;
	logic      f_stall;
	item_t     f_item;
	logic      q_valid;
	logic      q_stall;
	item_t     q_item;
	q_status_t q_stat;

	u8v_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_value (byte_value),
		.has_byte   (has_byte),
		.last       (last),
		.item_valid (f_valid),
		.item       (f_item),
		.item_stall (f_stall)
	);

	u8v_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_stall (f_stall),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_stall  (q_stall),
		.pop_item   (q_item),
		.status     (q_stat)
	);

	u8v_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (q_valid),
		.item_stall   (q_stall),
		.item         (q_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.string_valid (string_valid)
	);

	// The input is held back only by a full queue.
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled while queue has room");

	// The queue is never full and empty at once.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty");

	// A transferred verdict leaves unless a new one loads behind it.
	a_verdict_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !(q_valid && q_item.last)) |=> !out_valid)
		else $error("verdict repeated after transfer");

endmodule

>>> src/u8v_front.sv
module u8v_front
	import u8v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_value,
	input  logic       has_byte,
	input  logic       last,
	output logic       item_valid,
	output item_t      item,
	input  logic       item_stall
);

	logic      valid_s1;
	item_t     item_s1;
	lead_cls_t cls;

	// Classify the byte as a potential lead byte.
	always_comb begin
		priority if (byte_value < BYTE_ASCII_END) begin
			cls = (byte_value < BYTE_SPACE || byte_value == BYTE_DEL) ? CLS_CTRL : CLS_ASCII;
		end else if (byte_value >= BYTE_LEAD2_LO && byte_value <= BYTE_LEAD2_HI) begin
			cls = CLS_LEAD2;
		end else if (byte_value >= BYTE_LEAD3_LO && byte_value <= BYTE_LEAD3_HI) begin
			cls = CLS_LEAD3;
		end else if (byte_value >= BYTE_LEAD4_LO && byte_value <= BYTE_LEAD4_HI) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_BAD;
		end
	end

	// The front register holds while the queue is full.
	assign in_stall = valid_s1 && item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.has_byte <= has_byte;
			item_s1.last     <= last;
			item_s1.cls      <= cls;
			item_s1.data     <= byte_value;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

>>> src/u8v_queue.sv
module u8v_queue
	import u8v_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_stall,
	input  item_t     push_item,
	output logic      pop_valid,
	input  logic      pop_stall,
	output item_t     pop_item,
	output q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;
	logic             push;
	logic             pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign empty      = (count_q == '0);
	assign push       = push_valid && !full;
	assign pop        = !empty && !pop_stall;
	assign push_stall = full;
	assign pop_valid  = !empty;
	assign pop_item   = mem_q[rd_ptr_q];
	assign status     = '{full: full, empty: empty};

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/u8v_back.sv
module u8v_back
	import u8v_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  out_valid,
	input  logic  out_stall,
	output logic  string_valid
);

	logic [CP_W-1:0] accum_q;
	logic [1:0]      pending_q;
	logic [1:0]      seq_len_q;
	logic            error_q;
	logic            out_valid_q;
	logic            string_valid_q;

	logic [CP_W-1:0] accum_d;
	logic [1:0]      pending_d;
	logic [1:0]      seq_len_d;
	logic            error_d;
	logic [CP_W-1:0] cp;
	logic [1:0]      pend_dec;
	logic            take;
	logic            ok;

	// Only a verdict item waits for the output register.
	assign item_stall = item.last && out_valid_q && out_stall;
	assign take       = item_valid && !item_stall;

	assign cp       = {accum_q[CP_W-7:0], item.data[5:0]};
	assign pend_dec = pending_q - 2'd1;

	// Decode one byte against the running state.
	always_comb begin
		accum_d   = accum_q;
		pending_d = pending_q;
		seq_len_d = seq_len_q;
		error_d   = error_q;
		if (item.has_byte) begin
			if (pending_q == 2'd0) begin
				unique case (item.cls)
					CLS_ASCII: begin
					end
					CLS_LEAD2: begin
						accum_d   = CP_W'(item.data[4:0]);
						pending_d = CONTS_2BYTE;
						seq_len_d = CONTS_2BYTE;
					end
					CLS_LEAD3: begin
						accum_d   = CP_W'(item.data[3:0]);
						pending_d = CONTS_3BYTE;
						seq_len_d = CONTS_3BYTE;
					end
					CLS_LEAD4: begin
						accum_d   = CP_W'(item.data[2:0]);
						pending_d = CONTS_4BYTE;
						seq_len_d = CONTS_4BYTE;
					end
					default: begin
						error_d   = 1'b1;
						accum_d   = '0;
						pending_d = 2'd0;
						seq_len_d = 2'd0;
					end
				endcase
			end else if (item.data[7:6] != 2'b10) begin
				error_d   = 1'b1;
				accum_d   = '0;
				pending_d = 2'd0;
				seq_len_d = 2'd0;
			end else if (pend_dec != 2'd0) begin
				accum_d   = cp;
				pending_d = pend_dec;
			end else if ((seq_len_q == CONTS_3BYTE && cp < CP_MIN_3BYTE) ||
					(seq_len_q == CONTS_4BYTE && cp < CP_MIN_4BYTE) ||
					(cp >= CP_C1_LO && cp <= CP_C1_HI) ||
					(cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
					(cp > CP_MAX)) begin
				error_d   = 1'b1;
				accum_d   = '0;
				pending_d = 2'd0;
				seq_len_d = 2'd0;
			end else begin
				accum_d   = '0;
				pending_d = 2'd0;
				seq_len_d = 2'd0;
			end
		end
	end

	assign ok = !error_d && (pending_d == 2'd0);

	// Running decoder state, cleared at the end of each string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= '0;
			pending_q <= 2'd0;
			seq_len_q <= 2'd0;
			error_q   <= 1'b0;
		end else if (take) begin
			if (item.last) begin
				accum_q   <= '0;
				pending_q <= 2'd0;
				seq_len_q <= 2'd0;
				error_q   <= 1'b0;
			end else begin
				accum_q   <= accum_d;
				pending_q <= pending_d;
				seq_len_q <= seq_len_d;
				error_q   <= error_d;
			end
		end
	end

	// Verdict output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last) begin
			string_valid_q <= ok;
		end
	end

	assign out_valid    = out_valid_q;
	assign string_valid = string_valid_q;

endmodule

>>> tb/tb_utf8_validator_no_controls_core.sv
`timescale 1ns / 1ps

module tb_utf8_validator_no_controls_core;
	import u8v_pkg::*;

	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = 8;

	// One transfer on the input channel, plus a flag that holds it back until
	// every verdict already owed has come out.
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
		logic       drain_first;
	} byte_xfer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] byte_value = 8'h00;
	logic       has_byte = 1'b0;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       string_valid;

	utf8_validator_no_controls_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_value  (byte_value),
		.has_byte    (has_byte),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.string_valid(string_valid)
	);

	// Bytes waiting to be sent, and verdicts owed by the block.
	byte_xfer_t bytes_to_send[$];
	logic       verdicts_due[$];
	logic [7:0] str_bytes[$];
	byte_xfer_t next_xfer;

	// Running decoder state of the predictor.
	logic [CP_W-1:0] cp_acc = '0;
	logic [1:0]      conts_due = '0;
	logic [1:0]      seq_conts = '0;
	logic            err_sticky = 1'b0;

	int items_built = 0;
	int transfers = 0;
	int verdicts_seen = 0;
	int valid_seen = 0;
	int mismatches = 0;
	int drains = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int recv_calm = 0;

	// Clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, a few long, and now
	// and then a calm stretch with no idling at all.
	function automatic int idle_span(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the predicted decoder by one accepted transfer and queue the
	// verdict when the transfer ends a string.
	task automatic advance_decoder(input logic [7:0] b, input logic hb, input logic lst);
		logic bad;
		bad = 1'b0;
		if (hb) begin
			if (conts_due == 2'd0) begin
				// Start of a character.
				if (b < BYTE_ASCII_END) begin
					bad = (b < BYTE_SPACE) || (b == BYTE_DEL);
				end else if (b >= BYTE_LEAD2_LO && b <= BYTE_LEAD2_HI) begin
					cp_acc = {16'd0, b[4:0]};
					conts_due = CONTS_2BYTE;
					seq_conts = CONTS_2BYTE;
				end else if (b >= BYTE_LEAD3_LO && b <= BYTE_LEAD3_HI) begin
					cp_acc = {17'd0, b[3:0]};
					conts_due = CONTS_3BYTE;
					seq_conts = CONTS_3BYTE;
				end else if (b >= BYTE_LEAD4_LO && b <= BYTE_LEAD4_HI) begin
					cp_acc = {18'd0, b[2:0]};
					conts_due = CONTS_4BYTE;
					seq_conts = CONTS_4BYTE;
				end else begin
					bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				// Continuation byte; range checks once the code point is whole.
				cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
				conts_due = conts_due - 2'd1;
				if (conts_due == 2'd0) begin
					bad = (seq_conts == CONTS_3BYTE && cp_acc < CP_MIN_3BYTE) ||
						(seq_conts == CONTS_4BYTE && cp_acc < CP_MIN_4BYTE) ||
						(cp_acc >= CP_C1_LO && cp_acc <= CP_C1_HI) ||
						(cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) ||
						(cp_acc > CP_MAX);
					cp_acc = '0;
					seq_conts = '0;
				end
			end
			if (bad) begin
				err_sticky = 1'b1;
				cp_acc = '0;
				conts_due = '0;
				seq_conts = '0;
			end
		end
		if (lst) begin
			verdicts_due.push_back(!err_sticky && conts_due == 2'd0);
			err_sticky = 1'b0;
			cp_acc = '0;
			conts_due = '0;
			seq_conts = '0;
		end
	endtask

	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Append the encoding of a code point with a forced byte count, so that
	// overlong and out-of-range forms can be built as easily as good ones.
	task automatic encode_cp(input logic [20:0] cp, input int nbytes);
		case (nbytes)
			1: begin
				str_bytes.push_back(cp[7:0]);
			end
			2: begin
				str_bytes.push_back({3'b110, cp[10:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// Turn the bytes in str_bytes into transfers, ending either on the final
	// byte or with a bare end marker, with idle transfers sprinkled in.
	task automatic emit_string(input bit end_on_byte, input bit drain, input int idle_pct);
		byte_xfer_t x;
		int n;
		n = str_bytes.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < idle_pct) begin
				x = '{data: 8'($urandom_range(0, 255)), has_byte: 1'b0, last: 1'b0,
					drain_first: drain && i == 0};
				bytes_to_send.push_back(x);
				drain = 1'b0;
			end
			x = '{data: str_bytes[i], has_byte: 1'b1, last: end_on_byte && i == n - 1,
				drain_first: drain && i == 0};
			bytes_to_send.push_back(x);
			items_built++;
		end
		if (!end_on_byte || n == 0) begin
			x = '{data: 8'($urandom_range(0, 255)), has_byte: 1'b0, last: 1'b1,
				drain_first: drain && n == 0};
			bytes_to_send.push_back(x);
			items_built++;
		end
		str_bytes.delete();
	endtask

	// One random character: mostly well formed, the rest one of the faults.
	task automatic add_random_char();
		int r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			encode_cp(21'($urandom_range(21'h20, 21'h7E)), 1);
		end else if (r < 48) begin
			encode_cp(21'($urandom_range(21'hA0, 21'h7FF)), 2);
		end else if (r < 66) begin
			// Three-byte range with the surrogate block cut out.
			b = 8'h00;
			encode_cp(21'($urandom_range(21'h800, 21'hF7FF)) +
				(($urandom_range(0, 1) != 0) ? 21'h800 : 21'h0), 3);
			if (str_bytes[str_bytes.size() - 3] == 8'hED && str_bytes[str_bytes.size() - 2][5]) begin
				repeat (3) void'(str_bytes.pop_back());
				encode_cp(21'($urandom_range(21'hE000, 21'hFFFF)), 3);
			end
		end else if (r < 84) begin
			encode_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
		end else if (r < 86) begin
			// Control character.
			encode_cp(($urandom_range(0, 7) == 0) ? 21'h7F : 21'($urandom_range(0, 31)), 1);
		end else if (r < 88) begin
			encode_cp(21'($urandom_range(21'h80, 21'h9F)), 2);
		end else if (r < 90) begin
			encode_cp(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
		end else if (r < 92) begin
			// Overlong form, including the bad leads 0xC0 and 0xC1.
			case ($urandom_range(0, 2))
				0: encode_cp(21'($urandom_range(21'h0, 21'h7F)), 2);
				1: encode_cp(21'($urandom_range(21'h0, 21'h7FF)), 3);
				default: encode_cp(21'($urandom_range(21'h0, 21'hFFFF)), 4);
			endcase
		end else if (r < 94) begin
			encode_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
		end else if (r < 97) begin
			str_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// Lead byte followed by something that is not a continuation.
			str_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
			b = 8'($urandom_range(0, 255));
			if (b[7:6] == 2'b10)
				b[6] = 1'b1;
			str_bytes.push_back(b);
		end
	endtask

	// Stimulus: directed strings, then random strings, then wait for the end.
	initial begin
		int first;
		int nchars;
		int r;
		bit drain_next;

		// Empty string, printable and control ASCII, bad lead bytes.
		emit_string(1'b0, 1'b0, 0);
		str_bytes = '{8'h20};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'h1F};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'h7F};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'hC1};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'hF5};
		emit_string(1'b1, 1'b0, 0);
		// Good two-byte character, then a C1 code point.
		str_bytes = '{8'hC2, 8'hA0};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'hC2, 8'h80};
		emit_string(1'b1, 1'b0, 0);
		// Overlong three-byte form, surrogate, value above the Unicode range.
		str_bytes = '{8'hE0, 8'h80, 8'h80};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'hED, 8'hA0, 8'h80};
		emit_string(1'b1, 1'b0, 0);
		str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
		emit_string(1'b1, 1'b0, 0);
		// Truncated sequence closed by a bare end, then a bad continuation.
		str_bytes = '{8'hC2};
		emit_string(1'b0, 1'b0, 0);
		str_bytes = '{8'hC2, 8'h41};
		emit_string(1'b1, 1'b0, 0);
		// An idle transfer ahead of a byte that ends its string.
		str_bytes = '{8'h41};
		emit_string(1'b1, 1'b0, 100);

		// Random strings; the first one waits for the directed verdicts.
		drain_next = 1'b1;
		first = items_built;
		while (items_built - first < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			nchars = (r < 6) ? 0 : (r < 92) ? $urandom_range(1, 5) : $urandom_range(10, 20);
			repeat (nchars) add_random_char();
			if ($urandom_range(0, 19) == 0) begin
				// Sequence cut short at the end of the string.
				encode_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), $urandom_range(2, 4));
				repeat ($urandom_range(1, 2)) void'(str_bytes.pop_back());
			end
			emit_string(1'($urandom_range(0, 1)), drain_next, 4);
			drain_next = ($urandom_range(0, 49) == 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_to_send.size() != 0 || in_valid)
			@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d transfers; checked %0d string verdicts (%0d valid, %0d rejected).",
			transfers, verdicts_seen, valid_seen, verdicts_seen - valid_seen);
		$display("Sender drained the block %0d times; %0d mismatches.", drains, mismatches);
		if (mismatches == 0) begin
			$display("tb_utf8_validator_no_controls_core: PASS");
		end else begin
			$display("tb_utf8_validator_no_controls_core: FAIL");
		end
		$finish;
	end

	// Driver: predict on each accepted transfer, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_decoder(byte_value, has_byte, last);
				transfers++;
			end
			if (in_valid && in_stall) begin
				// Hold the stalled transfer as it is.
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (bytes_to_send.size() != 0 &&
				!(bytes_to_send[0].drain_first && verdicts_due.size() != 0)) begin
				next_xfer = bytes_to_send.pop_front();
				if (next_xfer.drain_first)
					drains++;
				byte_value <= next_xfer.data;
				has_byte <= next_xfer.has_byte;
				last <= next_xfer.last;
				in_valid <= 1'b1;
				send_gap = idle_span(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each verdict with the oldest one owed, then stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				verdicts_seen++;
				if (string_valid === 1'b1)
					valid_seen++;
				if (verdicts_due.size() == 0) begin
					log_mismatch($sformatf("verdict %b with no string pending", string_valid));
				end else if (string_valid !== verdicts_due[0]) begin
					log_mismatch($sformatf("string_valid expected %b, got %b",
						verdicts_due[0], string_valid));
					void'(verdicts_due.pop_front());
				end else begin
					void'(verdicts_due.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = idle_span(recv_calm);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d verdicts outstanding.",
				cycle_count, verdicts_due.size());
			$display("tb_utf8_validator_no_controls_core: FAIL");
			$finish;
		end
	end

endmodule
